/* rtl/core/julia_escape_time_pixel_macros.svh */
// Assertion macros shared by the escape-time pixel RTL.
// Expects i_clk and active-low i_rst_n in the including module.
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication
`define JETP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JETP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/jetp_pkg.sv */
// Shared types and constants for the escape-time pixel engine.
// No dependencies.
`timescale 1ns / 1ps

package jetp_pkg;

    localparam int FRAC      = 28;
    localparam int ZW        = 36;
    localparam int CW        = 32;
    localparam int STEP_W    = 28;
    localparam int ITER_W    = 8;
    localparam int PIX_W     = 10;
    localparam int PAL_OUT_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int OFS_W     = 13;
    localparam int PRD_W     = OFS_W + STEP_W + 1;
    localparam int MUL_W     = FRAC + 2;
    localparam int PROD_W    = 2 * MUL_W;

    localparam int WIDTH_DEF   = 800;
    localparam int HEIGHT_DEF  = 520;
    localparam int PALETTE_DEF = 2048;
    localparam int CELLS_DEF   = 4;

    localparam logic signed [ZW-1:0] Z_TWO  = ZW'(1) <<< (FRAC + 1);
    localparam logic signed [ZW-1:0] Z_FOUR = ZW'(1) <<< (FRAC + 2);

    localparam logic signed [PRD_W-1:0] Z_MAX = PRD_W'((64'sd1 <<< (ZW - 1)) - 64'sd1);
    localparam logic signed [PRD_W-1:0] Z_MIN = PRD_W'(-(64'sd1 <<< (ZW - 1)));

    localparam logic [CW-1:0]     C_REAL_RST   = CW'(76503450);
    localparam logic [CW-1:0]     C_IMAG_RST   = CW'(2684355);
    localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(1845494);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL   = 2'd0,
        CFG_C_IMAG   = 2'd1,
        CFG_STEP     = 2'd2,
        CFG_MAX_ITER = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                   valid;
        logic                   done;
        logic [ITER_W-1:0]      count;
        logic signed [ZW-1:0]   zx;
        logic signed [ZW-1:0]   zy;
    } t_cell_bus;

    function automatic logic signed [ZW-1:0] sat_z(input logic signed [PRD_W-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > Z_MAX) begin
            r = ZW'(Z_MAX);
        end else if (v < Z_MIN) begin
            r = ZW'(Z_MIN);
        end else begin
            r = ZW'(v);
        end
        return r;
    endfunction

endpackage

/* rtl/core/jetp_cell.sv */
// One iteration cell of the ring: z = z*z + c with escape and limit checks.
// Two register stages (squares, then update). Uses jetp_pkg and the macro header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_macros.svh"

module jetp_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  jetp_pkg::t_cell_bus              i_bus,
    input  logic signed [jetp_pkg::CW-1:0]   i_c_real,
    input  logic signed [jetp_pkg::CW-1:0]   i_c_imag,
    input  logic [jetp_pkg::ITER_W-1:0]      i_max_iter,
    output jetp_pkg::t_cell_bus              o_bus
);

    logic                                   w_big;
    logic                                   w_lim;
    logic signed [jetp_pkg::MUL_W-1:0]      w_ax;
    logic signed [jetp_pkg::MUL_W-1:0]      w_ay;

    logic                                   r_v;
    logic                                   r_done;
    logic [jetp_pkg::ITER_W-1:0]            r_count;
    logic signed [jetp_pkg::PROD_W-1:0]     r_pxx;
    logic signed [jetp_pkg::PROD_W-1:0]     r_pyy;
    logic signed [jetp_pkg::PROD_W-1:0]     r_pxy;

    logic signed [jetp_pkg::ZW-1:0]         w_sx;
    logic signed [jetp_pkg::ZW-1:0]         w_sy;
    logic signed [jetp_pkg::ZW-1:0]         w_sxy;
    logic                                   w_esc;

    logic                                   n_done;
    logic [jetp_pkg::ITER_W-1:0]            n_count;
    logic signed [jetp_pkg::ZW-1:0]         n_zx;
    logic signed [jetp_pkg::ZW-1:0]         n_zy;

    logic                                   r_v2;
    logic                                   r_done2;
    logic [jetp_pkg::ITER_W-1:0]            r_count2;
    logic signed [jetp_pkg::ZW-1:0]         r_zx2;
    logic signed [jetp_pkg::ZW-1:0]         r_zy2;

    // stage 1: bounds and limit checks, squares
    assign w_big = (i_bus.zx >= jetp_pkg::Z_TWO) || (i_bus.zx <= -jetp_pkg::Z_TWO) ||
                   (i_bus.zy >= jetp_pkg::Z_TWO) || (i_bus.zy <= -jetp_pkg::Z_TWO);
    assign w_lim = i_bus.count >= i_max_iter;
    assign w_ax  = i_bus.zx[jetp_pkg::MUL_W-1:0];
    assign w_ay  = i_bus.zy[jetp_pkg::MUL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done  <= i_bus.done || w_big || w_lim;
        r_count <= i_bus.count;
        r_pxx   <= jetp_pkg::PROD_W'(w_ax * w_ax);
        r_pyy   <= jetp_pkg::PROD_W'(w_ay * w_ay);
        r_pxy   <= jetp_pkg::PROD_W'(w_ax * w_ay);
    end

    // stage 2: floor shift, magnitude test, update
    assign w_sx  = jetp_pkg::ZW'(r_pxx >>> jetp_pkg::FRAC);
    assign w_sy  = jetp_pkg::ZW'(r_pyy >>> jetp_pkg::FRAC);
    assign w_sxy = jetp_pkg::ZW'(r_pxy >>> (jetp_pkg::FRAC - 1));
    assign w_esc = (w_sx + w_sy) >= jetp_pkg::Z_FOUR;

    always_comb begin
        if (r_done || w_esc) begin
            n_done  = 1'b1;
            n_count = r_count;
            n_zx    = w_sx;
            n_zy    = w_sy;
        end else begin
            n_done  = 1'b0;
            n_count = r_count + 1'b1;
            n_zx    = w_sx - w_sy + jetp_pkg::ZW'(i_c_real);
            n_zy    = w_sxy + jetp_pkg::ZW'(i_c_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done2  <= n_done;
        r_count2 <= n_count;
        r_zx2    <= n_zx;
        r_zy2    <= n_zy;
    end

    assign o_bus = '{valid: r_v2, done: r_done2, count: r_count2, zx: r_zx2, zy: r_zy2};

    `JETP_ASSERT_NEXT(a_valid_flows, r_v, r_v2, "cell lost an item between stages")
    `JETP_ASSERT_NEXT(a_done_sticky, r_v && r_done, r_done2 && (r_count2 == $past(r_count)), "finished item changed in cell")
    `JETP_ASSERT_NEXT(a_limit_stops, i_bus.valid && (i_bus.count >= i_max_iter), r_done, "item passed the iteration limit")

endmodule

/* rtl/core/jetp_div.sv */
// Restoring divider, one quotient bit per cycle, for the palette index.
// 8-bit divisor. Uses no package items.
`timescale 1ns / 1ps

module jetp_div #(
    parameter int NUM_W = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [7:0]         i_den,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_quot;
    logic [7:0]         r_rem;
    logic [7:0]         r_den;

    logic [8:0]         n_trial;
    logic               n_ge;
    logic [7:0]         n_rem;

    always_comb begin
        n_trial = {r_rem, r_quot[NUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_rem   = n_ge ? 8'(n_trial - {1'b0, r_den}) : n_trial[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], n_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/julia_escape_time_pixel.sv */
// Escaped pixels also pass through the palette divide, which is DIV_W bits wide
// (DIV_W = max(8 + clog2(PALETTE_SIZE), 11), 19 by default).
// Throughput: one item at a time; the next start is taken the cycle after o_done.
// The ring of NUM_CELLS iteration cells sets the run time.
// Synchronous active-low reset returns to idle and loads register defaults.
// o_done pulses one cycle with the result; the receiver cannot stall.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_macros.svh"

module julia_escape_time_pixel #(
    parameter int WIDTH        = jetp_pkg::WIDTH_DEF,
    parameter int HEIGHT       = jetp_pkg::HEIGHT_DEF,
    parameter int PALETTE_SIZE = jetp_pkg::PALETTE_DEF,
    parameter int NUM_CELLS    = jetp_pkg::CELLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [jetp_pkg::PIX_W-1:0]          i_pixel_x,
    input  logic [jetp_pkg::PIX_W-1:0]          i_pixel_y,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [jetp_pkg::ITER_W-1:0]         o_iter_count,
    output logic                                o_escaped,
    output logic [jetp_pkg::PAL_OUT_W-1:0]      o_palette_index,
    output logic [jetp_pkg::PIX_W-1:0]          o_screen_x,
    output logic [jetp_pkg::PIX_W-1:0]          o_screen_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jetp_pkg::CW-1:0]             i_cfg_data
);

    localparam int PAL_W = $clog2(PALETTE_SIZE);
    localparam int NUM_W = jetp_pkg::ITER_W + PAL_W;
    localparam int DIV_W = (NUM_W > jetp_pkg::PAL_OUT_W) ? NUM_W : jetp_pkg::PAL_OUT_W;

    localparam logic signed [jetp_pkg::OFS_W-1:0] X_CTR = jetp_pkg::OFS_W'(WIDTH / 2);
    localparam logic signed [jetp_pkg::OFS_W-1:0] Y_CTR = jetp_pkg::OFS_W'(HEIGHT / 2);

    jetp_pkg::t_state                       r_state;
    jetp_pkg::t_state                       n_state;

    logic signed [jetp_pkg::CW-1:0]         r_c_real;
    logic signed [jetp_pkg::CW-1:0]         r_c_imag;
    logic [jetp_pkg::STEP_W-1:0]            r_step;
    logic [jetp_pkg::ITER_W-1:0]            r_max_iter;

    logic [jetp_pkg::PIX_W-1:0]             r_px;
    logic [jetp_pkg::PIX_W-1:0]             r_py;
    logic [jetp_pkg::PIX_W-1:0]             r_sx;
    logic signed [jetp_pkg::OFS_W-1:0]      w_dx;
    logic signed [jetp_pkg::OFS_W-1:0]      w_dy;
    logic signed [jetp_pkg::STEP_W:0]       w_step_s;
    logic signed [jetp_pkg::PRD_W-1:0]      r_prod_x;
    logic signed [jetp_pkg::PRD_W-1:0]      r_prod_y;

    jetp_pkg::t_cell_bus                    w_bus [NUM_CELLS+1];
    jetp_pkg::t_cell_bus                    w_head;
    jetp_pkg::t_cell_bus                    w_last;
    logic                                   w_fin;
    logic                                   w_fin_esc;

    logic                                   w_div_start;
    logic [DIV_W-1:0]                       w_num;
    logic                                   w_div_done;
    logic [DIV_W-1:0]                       w_quot;

    logic [jetp_pkg::ITER_W-1:0]            r_count;
    logic                                   r_esc;
    logic [jetp_pkg::PAL_OUT_W-1:0]         r_pal;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real   <= jetp_pkg::C_REAL_RST;
            r_c_imag   <= jetp_pkg::C_IMAG_RST;
            r_step     <= jetp_pkg::STEP_RST;
            r_max_iter <= jetp_pkg::MAX_ITER_RST;
        end else if (i_cfg_valid) begin
            case (jetp_pkg::t_cfg_idx'(i_cfg_index))
                jetp_pkg::CFG_C_REAL: begin
                    r_c_real <= i_cfg_data;
                end
                jetp_pkg::CFG_C_IMAG: begin
                    r_c_imag <= i_cfg_data;
                end
                jetp_pkg::CFG_STEP: begin
                    r_step <= i_cfg_data[jetp_pkg::STEP_W-1:0];
                end
                jetp_pkg::CFG_MAX_ITER: begin
                    r_max_iter <= i_cfg_data[jetp_pkg::ITER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jetp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jetp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = jetp_pkg::ST_MUL;
                end
            end
            jetp_pkg::ST_MUL: begin
                n_state = jetp_pkg::ST_LOAD;
            end
            jetp_pkg::ST_LOAD: begin
                n_state = jetp_pkg::ST_RUN;
            end
            jetp_pkg::ST_RUN: begin
                if (w_fin) begin
                    n_state = w_fin_esc ? jetp_pkg::ST_DIV : jetp_pkg::ST_OUT;
                end
            end
            jetp_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = jetp_pkg::ST_OUT;
                end
            end
            jetp_pkg::ST_OUT: begin
                n_state = jetp_pkg::ST_IDLE;
            end
            default: begin
                n_state = jetp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy = r_state != jetp_pkg::ST_IDLE;
        o_done = r_state == jetp_pkg::ST_OUT;
    end

    // start point
    assign w_dx     = $signed({3'b000, r_px}) - X_CTR;
    assign w_dy     = $signed({3'b000, r_py}) - Y_CTR;
    assign w_step_s = $signed({1'b0, r_step});

    always_ff @(posedge i_clk) begin
        if ((r_state == jetp_pkg::ST_IDLE) && i_start) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
            r_sx <= jetp_pkg::PIX_W'(WIDTH - 1) - i_pixel_x;
        end
        if (r_state == jetp_pkg::ST_MUL) begin
            r_prod_x <= jetp_pkg::PRD_W'(w_dx * w_step_s);
            r_prod_y <= jetp_pkg::PRD_W'(w_dy * w_step_s);
        end
    end

    // ring of iteration cells
    assign w_last = w_bus[NUM_CELLS];

    always_comb begin
        if (r_state == jetp_pkg::ST_LOAD) begin
            w_head = '{valid: 1'b1, done: 1'b0, count: '0,
                       zx: jetp_pkg::sat_z(r_prod_x), zy: jetp_pkg::sat_z(r_prod_y)};
        end else begin
            w_head       = w_last;
            w_head.valid = w_last.valid && !w_last.done;
        end
    end

    assign w_bus[0] = w_head;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        jetp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_bus      (w_bus[g]),
            .i_c_real   (r_c_real),
            .i_c_imag   (r_c_imag),
            .i_max_iter (r_max_iter),
            .o_bus      (w_bus[g+1])
        );
    end

    assign w_fin     = w_last.valid && w_last.done;
    assign w_fin_esc = w_last.count < r_max_iter;

    // palette index divide
    assign w_div_start = (r_state == jetp_pkg::ST_RUN) && w_fin && w_fin_esc;
    assign w_num       = DIV_W'(w_last.count) * DIV_W'(PALETTE_SIZE - 1);

    jetp_div #(
        .NUM_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_max_iter),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if ((r_state == jetp_pkg::ST_RUN) && w_fin) begin
            r_count <= w_last.count;
            r_esc   <= w_fin_esc;
            r_pal   <= '0;
        end else if ((r_state == jetp_pkg::ST_DIV) && w_div_done) begin
            r_pal <= w_quot[jetp_pkg::PAL_OUT_W-1:0];
        end
    end

    assign o_iter_count    = r_count;
    assign o_escaped       = r_esc;
    assign o_palette_index = r_pal;
    assign o_screen_x      = r_sx;
    assign o_screen_y      = r_py;

    `JETP_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe held longer than one cycle")
    `JETP_ASSERT_NOW(a_esc_lim, o_done && o_escaped, o_iter_count < r_max_iter, "escape at limit")
    `JETP_ASSERT_NOW(a_in_pal0, o_done && !o_escaped, o_palette_index == '0, "palette set")
    `JETP_ASSERT_NOW(a_fin_in_run, w_fin, r_state == jetp_pkg::ST_RUN, "finish outside run")

endmodule

/* verif/tb_julia_escape_time_pixel.sv */
// Self-checking testbench for julia_escape_time_pixel: drives pixel items and register writes,
// predicts each escape-time result in a scoreboard class and compares it field by field.
// Depends on jetp_pkg and the julia_escape_time_pixel RTL.
`timescale 1ns / 1ps

module tb_julia_escape_time_pixel;
    import jetp_pkg::*;

    localparam int     IMG_W          = WIDTH_DEF;
    localparam int     IMG_H          = HEIGHT_DEF;
    localparam int     PAL_SIZE       = PALETTE_DEF;
    localparam longint ESC_TWO        = 64'sd1 <<< (FRAC + 1);
    localparam longint ESC_FOUR       = 64'sd1 <<< (FRAC + 2);
    localparam longint START_MAX      = (64'sd1 <<< (ZW - 1)) - 64'sd1;
    localparam longint START_MIN      = -(64'sd1 <<< (ZW - 1));
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PHASES         = 12;
    localparam int     PHASE_ITEMS    = 96;

    typedef struct packed {
        logic [ITER_W-1:0]    iter_count;
        logic                 escaped;
        logic [PAL_OUT_W-1:0] palette_index;
        logic [PIX_W-1:0]     screen_x;
        logic [PIX_W-1:0]     screen_y;
    } t_pixel_result;

    class t_pixel_scoreboard;
        t_pixel_result        expected_pixels[$];
        int unsigned          errors;
        logic signed [CW-1:0] c_real;
        logic signed [CW-1:0] c_imag;
        logic [STEP_W-1:0]    pixel_step;
        logic [ITER_W-1:0]    max_iter;

        function new();
            c_real     = C_REAL_RST;
            c_imag     = C_IMAG_RST;
            pixel_step = STEP_RST;
            max_iter   = MAX_ITER_RST;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < 100) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        function void write_reg(t_cfg_idx idx, logic [CW-1:0] data);
            case (idx)
                CFG_C_REAL:   c_real = data;
                CFG_C_IMAG:   c_imag = data;
                CFG_STEP:     pixel_step = data[STEP_W-1:0];
                CFG_MAX_ITER: max_iter = data[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function longint start_coord(logic [PIX_W-1:0] pix, longint centre);
            longint p;
            p = (longint'(pix) - centre) * longint'(pixel_step);
            if (p > START_MAX) p = START_MAX;
            if (p < START_MIN) p = START_MIN;
            return p;
        endfunction

        function t_pixel_result escape_time(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            longint        zx, zy, sx, sy, nx;
            int            n;
            t_pixel_result r;
            zx = start_coord(px, longint'(IMG_W / 2));
            zy = start_coord(py, longint'(IMG_H / 2));
            n  = 0;
            while (n < int'(max_iter)) begin
                if (zx >= ESC_TWO || zx <= -ESC_TWO || zy >= ESC_TWO || zy <= -ESC_TWO) break;
                sx = (zx * zx) >>> FRAC;
                sy = (zy * zy) >>> FRAC;
                if (sx + sy >= ESC_FOUR) break;
                nx = sx - sy + longint'(c_real);
                zy = ((2 * zx * zy) >>> FRAC) + longint'(c_imag);
                zx = nx;
                n++;
            end
            r.iter_count    = n[ITER_W-1:0];
            r.escaped       = (n < int'(max_iter));
            r.palette_index = '0;
            if (r.escaped) begin
                r.palette_index = PAL_OUT_W'((n * (PAL_SIZE - 1)) / int'(max_iter));
            end
            r.screen_x = PIX_W'(IMG_W - 1 - int'(px));
            r.screen_y = py;
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            expected_pixels.push_back(escape_time(px, py));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task check_pixel(t_pixel_result got);
            t_pixel_result want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("result with nothing pending, screen (%0d,%0d)",
                                 got.screen_x, got.screen_y));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.iter_count !== want.iter_count)
                report($sformatf("iter_count %0d, want %0d at screen (%0d,%0d)",
                                 got.iter_count, want.iter_count, want.screen_x, want.screen_y));
            if (got.escaped !== want.escaped)
                report($sformatf("escaped %0d, want %0d at screen (%0d,%0d)",
                                 got.escaped, want.escaped, want.screen_x, want.screen_y));
            if (got.palette_index !== want.palette_index)
                report($sformatf("palette_index %0d, want %0d at screen (%0d,%0d)",
                                 got.palette_index, want.palette_index,
                                 want.screen_x, want.screen_y));
            if (got.screen_x !== want.screen_x)
                report($sformatf("screen_x %0d, want %0d", got.screen_x, want.screen_x));
            if (got.screen_y !== want.screen_y)
                report($sformatf("screen_y %0d, want %0d", got.screen_y, want.screen_y));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_start         = 1'b0;
    logic [PIX_W-1:0]     i_pixel_x       = '0;
    logic [PIX_W-1:0]     i_pixel_y       = '0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CW-1:0]        i_cfg_data      = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [ITER_W-1:0]    o_iter_count;
    logic                 o_escaped;
    logic [PAL_OUT_W-1:0] o_palette_index;
    logic [PIX_W-1:0]     o_screen_x;
    logic [PIX_W-1:0]     o_screen_y;
    logic                 o_cfg_ready;

    t_pixel_scoreboard sb;
    t_pixel_result     seen;
    int                quiet_cycles = 0;

    julia_escape_time_pixel i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_busy          (o_busy),
        .o_done          (o_done),
        .o_iter_count    (o_iter_count),
        .o_escaped       (o_escaped),
        .o_palette_index (o_palette_index),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen.iter_count    = o_iter_count;
                seen.escaped       = o_escaped;
                seen.palette_index = o_palette_index;
                seen.screen_x      = o_screen_x;
                seen.screen_y      = o_screen_y;
                sb.check_pixel(seen);
            end
            if (i_start && !o_busy) begin
                sb.note_pixel(i_pixel_x, i_pixel_y);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
            if (o_done || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        i_start   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every pending item has produced its result
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || o_busy);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(logic [CW-1:0] cr, logic [CW-1:0] ci,
                             logic [CW-1:0] st, logic [CW-1:0] mi);
        drain();
        cfg_write(CFG_C_REAL, cr);
        cfg_write(CFG_C_IMAG, ci);
        cfg_write(CFG_STEP, st);
        cfg_write(CFG_MAX_ITER, mi);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_pixels(int count);
        int               left;
        int               burst;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        left = count;
        while (left > 0) begin
            burst = int'($urandom_range(1, 16));
            while (burst > 0 && left > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    px = PIX_W'($urandom_range(0, 1023));
                    py = PIX_W'($urandom_range(0, 1023));
                end else begin
                    px = PIX_W'($urandom_range(0, IMG_W - 1));
                    py = PIX_W'($urandom_range(0, IMG_H - 1));
                end
                send_pixel(px, py);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) pause(int'($urandom_range(1, 20)));
        end
    endtask

    function automatic logic [CW-1:0] pick_c();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        return $urandom();
    endfunction

    initial begin
        logic [CW-1:0] cr, ci, st, mi;
        int            sel;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: corners, centre, out-of-image coordinates
        send_pixel(PIX_W'(0), PIX_W'(0));
        send_pixel(PIX_W'(IMG_W - 1), PIX_W'(IMG_H - 1));
        send_pixel(PIX_W'(IMG_W / 2), PIX_W'(IMG_H / 2));
        send_pixel(10'h3FF, 10'h3FF);
        send_pixel(PIX_W'(0), 10'h3FF);
        send_pixel(10'h3FF, PIX_W'(0));
        send_pixel(PIX_W'(512), PIX_W'(256));
        send_pixel(PIX_W'(IMG_W / 2), PIX_W'(0));

        // zero step, zero c: every pixel sits at the origin until the limit
        configure(32'h0, 32'h0, 32'hF000_0000, 32'hFFFF_FFFF);
        send_pixel(PIX_W'(5), PIX_W'(7));
        send_pixel(PIX_W'(IMG_W - 1), PIX_W'(IMG_H - 1));

        // zero limit
        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0FFF_FFFF, 32'hFFFF_FF00);
        send_pixel(PIX_W'(IMG_W / 2), PIX_W'(IMG_H / 2));
        send_pixel(PIX_W'(0), PIX_W'(0));

        // single step, largest step and most negative c
        configure(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_pixel(PIX_W'(IMG_W / 2), PIX_W'(IMG_H / 2));
        send_pixel(PIX_W'(IMG_W / 2 + 1), PIX_W'(IMG_H / 2));
        send_pixel(PIX_W'(0), PIX_W'(0));
        send_pixel(10'h3FF, 10'h3FF);

        for (int ph = 0; ph < PHASES; ph++) begin
            cr  = pick_c();
            ci  = pick_c();
            sel = int'($urandom_range(0, 9));
            if (sel < 7)       st = $urandom_range(400000, 3000000);
            else if (sel == 7) st = $urandom() & 32'h0FFF_FFFF;
            else if (sel == 8) st = 32'h0FFF_FFFF;
            else               st = 32'h0;
            st = st | ($urandom() & 32'hF000_0000);
            if (ph == 0 || $urandom_range(0, 3) == 0) begin
                mi = (ph == 0) ? 255 : $urandom_range(100, 255);
            end else begin
                mi = $urandom_range(1, 60);
            end
            mi = mi | ($urandom() & 32'hFFFF_FF00);
            if (ph == PHASES - 2) begin
                cr = 32'h8000_0000;
                ci = 32'h7FFF_FFFF;
            end else if (ph == PHASES - 1) begin
                cr = 32'h7FFF_FFFF;
                ci = 32'h8000_0000;
            end
            configure(cr, ci, st, mi);
            run_pixels(PHASE_ITEMS);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("results still pending at end of run");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
